[sv/cft_pkg.sv]
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the CSV field tokenizer.
// Used by cft_ctrl, cft_dp and the top level; depends on nothing.
package cft_pkg;

    localparam logic [6:0] FIELD_LIMIT   = 7'd64;
    localparam logic [6:0] FIELD_CAP_RST = 7'd64;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_FEND = 2'd1;
    localparam logic [1:0] KIND_LEND = 2'd2;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_LEAD    = 3'd1,
        MODE_PLAIN   = 3'd2,
        MODE_QUOTED  = 3'd3,
        MODE_QSEEN   = 3'd4,
        MODE_SKIP    = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FLUSH,
        S_CHAR,
        S_FEND,
        S_LEND
    } state_t;

    typedef enum logic [1:0] {
        SEL_PEND,
        SEL_CHAR,
        SEL_FEND,
        SEL_LEND
    } sel_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic emit;
        sel_t sel;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic fend;
        logic lend;
        logic chr;
        logic flush_nz;
        logic flush_last;
        logic out_free;
    } status_t;

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    endfunction

endpackage

[sv/csv_field_tokenizer.sv]
`timescale 1ns / 1ps
// CSV field tokenizer, top level. A word is taken in the idle state and decoded in
// the next; each result it causes then goes out through the output register, and
// no new word is taken until its last result is emitted. A flushed whitespace
// run sends one held byte per cycle from pending memory while the output is free.
// rst_n clears parse state, counters and the field cap (to 64) asynchronously.
module csv_field_tokenizer
    import cft_pkg::*;
#(
    parameter int CELL_LENGTH   = 256,
    parameter int PENDING_DEPTH = 31
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_field_cap,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] out_char,
    output logic [5:0] field_index,
    output logic [6:0] field_total,
    output logic       cell_overflow,
    output logic       last
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    cft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cft_dp #(
        .CELL_LENGTH   (CELL_LENGTH),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_field_cap  (cfg_field_cap),
        .opcode         (opcode),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .out_char       (out_char),
        .field_index    (field_index),
        .field_total    (field_total),
        .cell_overflow  (cell_overflow),
        .last           (last)
    );

endmodule

[sv/cft_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the tokenizer: takes a word, runs its decode step and then
// steps through the results it causes. Depends on cft_pkg.
module cft_ctrl
    import cft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.emit    = 1'b0;
        cmd.sel     = SEL_CHAR;
        cmd.last    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.fend)
                begin
                    state_next = S_FEND;
                end
                else if (status.lend)
                begin
                    state_next = S_LEND;
                end
                else if (status.chr)
                begin
                    state_next = status.flush_nz ? S_FLUSH : S_CHAR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                cmd.sel = SEL_PEND;
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.flush_last)
                    begin
                        state_next = S_CHAR;
                    end
                end
            end
            S_CHAR:
            begin
                cmd.sel  = SEL_CHAR;
                cmd.last = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FEND:
            begin
                cmd.sel  = SEL_FEND;
                cmd.last = !status.lend;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.lend ? S_LEND : S_IDLE;
                end
            end
            S_LEND:
            begin
                cmd.sel  = SEL_LEND;
                cmd.last = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/cft_dp.sv]
`timescale 1ns / 1ps
// Datapath of the tokenizer: parse state, pending whitespace memory,
// word decode and the output register. Depends on cft_pkg.
module cft_dp
    import cft_pkg::*;
#(
    parameter int CELL_LENGTH   = 256,
    parameter int PENDING_DEPTH = 31
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output status_t    status,
    input  logic       cfg_valid,
    input  logic [6:0] cfg_field_cap,
    input  logic       opcode,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] out_char,
    output logic [5:0] field_index,
    output logic [6:0] field_total,
    output logic       cell_overflow,
    output logic       last
);

    localparam int CLW = $clog2(CELL_LENGTH);
    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam logic [CLW-1:0] CELL_MAX = CLW'(CELL_LENGTH - 1);
    localparam logic [PCW-1:0] PEND_MAX = PCW'(PENDING_DEPTH);

    logic [7:0]     pend_mem [PENDING_DEPTH];
    logic [7:0]     rd_data_reg;
    logic [PAW-1:0] rd_addr;
    logic           mem_we;

    logic [6:0]     field_cap_reg;
    logic           op_reg;
    logic [7:0]     byte_reg;
    mode_t          mode_reg, mode_next;
    logic [6:0]     count_reg, count_next;
    logic [CLW-1:0] cell_len_reg, cell_len_next;
    logic           seen_reg, seen_next;
    logic [PCW-1:0] pcount_reg, pcount_next;
    logic           ovf_reg, ovf_next;
    logic [PCW-1:0] flush_cnt_reg, flush_cnt_next;
    logic [PCW-1:0] flush_idx_reg, flush_idx_next;
    logic [7:0]     char_reg, char_next;

    logic           out_valid_reg;
    logic [1:0]     kind_reg, kind_next;
    logic [7:0]     ochar_reg, ochar_next;
    logic [5:0]     idx_reg, idx_next;
    logic [6:0]     total_reg, total_next;
    logic           oovf_reg, oovf_next;
    logic           last_reg;

    logic [6:0]     limit;
    logic           field_open;
    logic           cell_full;
    mode_t          mode_eff, mode_dec;
    logic           plan_fend;
    logic           plan_chr;
    logic           do_store;
    logic [7:0]     store_byte;
    logic [PCW-1:0] idx_inc;
    logic           out_free;

    assign limit      = (field_cap_reg > FIELD_LIMIT) ? FIELD_LIMIT : field_cap_reg;
    assign field_open = !(mode_reg == MODE_BETWEEN && count_reg >= limit);
    assign cell_full  = (cell_len_reg == CELL_MAX);
    assign mode_eff   = (mode_reg == MODE_BETWEEN) ? MODE_LEAD : mode_reg;
    assign idx_inc    = flush_idx_reg + PCW'(1);
    assign out_free   = !out_valid_reg || out_ready;

    // Decode the held word against the current parse state
    always_comb
    begin
        mode_dec   = mode_eff;
        plan_fend  = 1'b0;
        do_store   = 1'b0;
        store_byte = byte_reg;
        if (op_reg == OP_EOL)
        begin
            plan_fend = (mode_reg != MODE_BETWEEN);
        end
        else if (field_open)
        begin
            case (mode_eff)
                MODE_LEAD:
                begin
                    if (byte_reg == CH_SPACE || byte_reg == CH_TAB)
                    begin
                        mode_dec = MODE_LEAD;
                    end
                    else if (byte_reg == CH_QUOTE)
                    begin
                        mode_dec = MODE_QUOTED;
                    end
                    else if (byte_reg == CH_COMMA)
                    begin
                        plan_fend = 1'b1;
                    end
                    else
                    begin
                        mode_dec = MODE_PLAIN;
                        do_store = 1'b1;
                    end
                end
                MODE_PLAIN:
                begin
                    if (byte_reg == CH_COMMA)
                    begin
                        plan_fend = 1'b1;
                    end
                    else
                    begin
                        do_store = 1'b1;
                    end
                end
                MODE_QUOTED:
                begin
                    if (byte_reg == CH_QUOTE)
                    begin
                        mode_dec = MODE_QSEEN;
                    end
                    else
                    begin
                        do_store = 1'b1;
                    end
                end
                MODE_QSEEN:
                begin
                    if (byte_reg == CH_QUOTE)
                    begin
                        mode_dec   = MODE_QUOTED;
                        do_store   = 1'b1;
                        store_byte = CH_QUOTE;
                    end
                    else if (byte_reg == CH_COMMA)
                    begin
                        plan_fend = 1'b1;
                    end
                    else
                    begin
                        mode_dec = MODE_SKIP;
                    end
                end
                default:
                begin
                    if (byte_reg == CH_COMMA)
                    begin
                        plan_fend = 1'b1;
                    end
                    else
                    begin
                        mode_dec = MODE_SKIP;
                    end
                end
            endcase
        end
        plan_chr = do_store && !cell_full && !is_space(store_byte);
    end

    // State updates: decode step first, then the ones tied to emitted results
    always_comb
    begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        cell_len_next  = cell_len_reg;
        seen_next      = seen_reg;
        pcount_next    = pcount_reg;
        ovf_next       = ovf_reg;
        flush_cnt_next = flush_cnt_reg;
        flush_idx_next = flush_idx_reg;
        char_next      = char_reg;
        mem_we         = 1'b0;
        if (cmd.exec && op_reg == OP_DATA && field_open && !plan_fend)
        begin
            mode_next = mode_dec;
            if (do_store)
            begin
                if (cell_full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    cell_len_next = cell_len_reg + CLW'(1);
                    if (is_space(store_byte))
                    begin
                        if (seen_reg)
                        begin
                            if (pcount_reg < PEND_MAX)
                            begin
                                mem_we      = 1'b1;
                                pcount_next = pcount_reg + PCW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // hand the held run to the flush sequence
                        flush_cnt_next = pcount_reg;
                        flush_idx_next = '0;
                        pcount_next    = '0;
                        seen_next      = 1'b1;
                        char_next      = store_byte;
                    end
                end
            end
        end
        if (cmd.emit)
        begin
            case (cmd.sel)
                SEL_PEND:
                begin
                    flush_idx_next = idx_inc;
                end
                SEL_FEND:
                begin
                    if (count_reg != 7'd127)
                    begin
                        count_next = count_reg + 7'd1;
                    end
                    mode_next     = MODE_BETWEEN;
                    cell_len_next = '0;
                    seen_next     = 1'b0;
                    pcount_next   = '0;
                    ovf_next      = 1'b0;
                end
                SEL_LEND:
                begin
                    count_next    = '0;
                    mode_next     = MODE_BETWEEN;
                    cell_len_next = '0;
                    seen_next     = 1'b0;
                    pcount_next   = '0;
                    ovf_next      = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Prefetch: keep rd_data_reg on the entry the flush is about to send
    always_comb
    begin
        if (cmd.exec)
        begin
            rd_addr = '0;
        end
        else if (cmd.emit && cmd.sel == SEL_PEND && idx_inc < PEND_MAX)
        begin
            rd_addr = idx_inc[PAW-1:0];
        end
        else if (flush_idx_reg < PEND_MAX)
        begin
            rd_addr = flush_idx_reg[PAW-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pend_mem[pcount_reg[PAW-1:0]] <= store_byte;
        end
        rd_data_reg <= pend_mem[rd_addr];
    end

    always_comb
    begin
        kind_next  = KIND_CHAR;
        ochar_next = 8'd0;
        idx_next   = count_reg[5:0];
        total_next = 7'd0;
        oovf_next  = ovf_reg;
        case (cmd.sel)
            SEL_PEND:
            begin
                ochar_next = rd_data_reg;
            end
            SEL_CHAR:
            begin
                ochar_next = char_reg;
            end
            SEL_FEND:
            begin
                kind_next = KIND_FEND;
            end
            SEL_LEND:
            begin
                kind_next  = KIND_LEND;
                idx_next   = 6'd0;
                total_next = count_reg;
                oovf_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_cap_reg <= FIELD_CAP_RST;
            mode_reg      <= MODE_BETWEEN;
            count_reg     <= '0;
            cell_len_reg  <= '0;
            seen_reg      <= 1'b0;
            pcount_reg    <= '0;
            ovf_reg       <= 1'b0;
            flush_cnt_reg <= '0;
            flush_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                field_cap_reg <= cfg_field_cap;
            end
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            cell_len_reg  <= cell_len_next;
            seen_reg      <= seen_next;
            pcount_reg    <= pcount_next;
            ovf_reg       <= ovf_next;
            flush_cnt_reg <= flush_cnt_next;
            flush_idx_reg <= flush_idx_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            byte_reg <= in_byte;
        end
        if (cmd.emit)
        begin
            kind_reg  <= kind_next;
            ochar_reg <= ochar_next;
            idx_reg   <= idx_next;
            total_reg <= total_next;
            oovf_reg  <= oovf_next;
            last_reg  <= cmd.last;
        end
    end

    assign status.fend       = plan_fend;
    assign status.lend       = (op_reg == OP_EOL);
    assign status.chr        = plan_chr;
    assign status.flush_nz   = (pcount_reg != '0);
    assign status.flush_last = (idx_inc == flush_cnt_reg);
    assign status.out_free   = out_free;

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign out_char      = ochar_reg;
    assign field_index   = idx_reg;
    assign field_total   = total_reg;
    assign cell_overflow = oovf_reg;
    assign last          = last_reg;

endmodule

[sv/cft_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the CSV field tokenizer, bound to the top level.
// Depends on cft_pkg for the result kind codes.
module cft_checker
    import cft_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] result_kind,
    input logic [7:0] out_char,
    input logic [5:0] field_index,
    input logic [6:0] field_total,
    input logic       cell_overflow,
    input logic       last
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(out_char) && $stable(field_index) && $stable(last))
        else $error("output word changed while stalled");

    a_lend_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_LEND |-> last
            && field_index == 6'd0 && !cell_overflow)
        else $error("line end word malformed");

    a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_LEND |-> field_total == 7'd0)
        else $error("field total outside line end");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_kind == KIND_CHAR || result_kind == KIND_FEND
            || result_kind == KIND_LEND)
        else $error("unused result kind");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_CHAR |-> out_char == 8'd0)
        else $error("character on a non-character word");

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (.*);

[bench/tb_token_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the CSV field tokenizer bench: tracks the tokenizer state,
// predicts the result words of every accepted input word and checks them. Depends on cft_pkg.
package tb_token_pkg;
    import cft_pkg::*;

    // Match the default parameters of the instance under test.
    localparam int CELL_LEN   = 256;
    localparam int HOLD_DEPTH = 31;

    localparam logic [7:0] WS_FIRST = 8'h09;
    localparam logic [7:0] WS_LAST  = 8'h0D;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [5:0] idx;
        logic [6:0] total;
        logic       ovf;
        logic       last;
    } token_t;

    class token_scoreboard;
        logic [6:0] limit_reg;
        mode_t      mode;
        logic [6:0] field_cnt;
        int         cell_len;
        logic       seen_text;
        logic [7:0] held_ws[HOLD_DEPTH];
        int         held_cnt;
        logic       ovf;
        token_t     step_out[$];
        token_t     tokens_due[$];
        int         errors;
        int         checked;

        function new();
            limit_reg = FIELD_CAP_RST;
            mode      = MODE_BETWEEN;
            field_cnt = '0;
            errors    = 0;
            checked   = 0;
            clear_field();
        endfunction

        function void clear_field();
            cell_len  = 0;
            seen_text = 1'b0;
            held_cnt  = 0;
            ovf       = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] b);
            return (b == CH_SPACE) || (b >= WS_FIRST && b <= WS_LAST);
        endfunction

        function void emit(logic [1:0] kind, logic [7:0] ch, logic [5:0] idx,
                           logic [6:0] total, logic flag);
            token_t r;
            r.kind  = kind;
            r.ch    = ch;
            r.idx   = idx;
            r.total = total;
            r.ovf   = flag;
            r.last  = 1'b0;
            step_out.push_back(r);
        endfunction

        // Take one content byte: trim leading blanks, hold trailing ones back.
        function void take_byte(logic [7:0] b);
            if (cell_len >= CELL_LEN - 1)
            begin
                ovf = 1'b1;
                return;
            end
            cell_len++;
            if (is_blank(b))
            begin
                if (!seen_text)
                    return;
                if (held_cnt < HOLD_DEPTH)
                begin
                    held_ws[held_cnt] = b;
                    held_cnt++;
                end
                else
                    ovf = 1'b1;
                return;
            end
            for (int i = 0; i < held_cnt; i++)
                emit(KIND_CHAR, held_ws[i], field_cnt[5:0], 7'd0, ovf);
            held_cnt  = 0;
            seen_text = 1'b1;
            emit(KIND_CHAR, b, field_cnt[5:0], 7'd0, ovf);
        endfunction

        function void close_field();
            emit(KIND_FEND, 8'd0, field_cnt[5:0], 7'd0, ovf);
            if (field_cnt < 7'd127)
                field_cnt++;
            clear_field();
            mode = MODE_BETWEEN;
        endfunction

        function void predict_tokens(logic op, logic [7:0] b);
            logic [6:0] limit;
            token_t     r;
            limit = (limit_reg > FIELD_LIMIT) ? FIELD_LIMIT : limit_reg;
            step_out.delete();
            if (op == OP_EOL)
            begin
                if (mode != MODE_BETWEEN)
                    close_field();
                emit(KIND_LEND, 8'd0, 6'd0, field_cnt, 1'b0);
                mode      = MODE_BETWEEN;
                field_cnt = '0;
                clear_field();
            end
            else
            begin
                if (mode == MODE_BETWEEN)
                begin
                    // drop bytes past the field limit
                    if (field_cnt >= limit)
                        return;
                    clear_field();
                    mode = MODE_LEAD;
                end
                case (mode)
                    MODE_LEAD:
                    begin
                        if (!(b == CH_SPACE || b == CH_TAB))
                        begin
                            if (b == CH_QUOTE)
                                mode = MODE_QUOTED;
                            else if (b == CH_COMMA)
                                close_field();
                            else
                            begin
                                mode = MODE_PLAIN;
                                take_byte(b);
                            end
                        end
                    end
                    MODE_PLAIN:
                    begin
                        if (b == CH_COMMA)
                            close_field();
                        else
                            take_byte(b);
                    end
                    MODE_QUOTED:
                    begin
                        if (b == CH_QUOTE)
                            mode = MODE_QSEEN;
                        else
                            take_byte(b);
                    end
                    MODE_QSEEN:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            mode = MODE_QUOTED;
                            take_byte(CH_QUOTE);
                        end
                        else if (b == CH_COMMA)
                            close_field();
                        else
                            mode = MODE_SKIP;
                    end
                    default:
                    begin
                        if (b == CH_COMMA)
                            close_field();
                        else
                            mode = MODE_SKIP;
                    end
                endcase
            end
            foreach (step_out[i])
            begin
                r      = step_out[i];
                r.last = (i == step_out.size() - 1);
                tokens_due.push_back(r);
            end
        endfunction

        function int waiting();
            return tokens_due.size();
        endfunction

        task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
            $display("%0t: result %0d %s mismatch: got 0x%0h, want 0x%0h",
                     $time, checked, what, got, want);
            errors++;
        endtask

        task check_token(token_t got);
            token_t want;
            if (tokens_due.size() == 0)
            begin
                report_mismatch("unrequested result_kind", 8'(got.kind), 8'd0);
                checked++;
                return;
            end
            want = tokens_due.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("result_kind", 8'(got.kind), 8'(want.kind));
            if (got.ch !== want.ch)
                report_mismatch("out_char", got.ch, want.ch);
            if (got.idx !== want.idx)
                report_mismatch("field_index", 8'(got.idx), 8'(want.idx));
            if (got.total !== want.total)
                report_mismatch("field_total", 8'(got.total), 8'(want.total));
            if (got.ovf !== want.ovf)
                report_mismatch("cell_overflow", 8'(got.ovf), 8'(want.ovf));
            if (got.last !== want.last)
                report_mismatch("last", 8'(got.last), 8'(want.last));
            checked++;
        endtask
    endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Top-level bench for csv_field_tokenizer: drives lines of bytes with random gaps
// and output stalls, checks every result word against token_scoreboard.
// Depends on cft_pkg, tb_token_pkg and the tokenizer RTL.
module tb_top;
    import cft_pkg::*;
    import tb_token_pkg::*;

    localparam int RANDOM_WORDS   = 210;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RX_HOLD_CYCLES = 200;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_field_cap;
    logic       in_valid;
    logic       in_ready;
    logic       opcode;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] result_kind;
    logic [7:0] out_char;
    logic [5:0] field_index;
    logic [6:0] field_total;
    logic       cell_overflow;
    logic       last;

    token_scoreboard sb;
    logic [8:0]      line_q[$];
    bit              tx_burst;
    bit              rx_hold_req;
    int              items_sent;

    csv_field_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_field_cap (cfg_field_cap),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .out_char      (out_char),
        .field_index   (field_index),
        .field_total   (field_total),
        .cell_overflow (cell_overflow),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin : sample
        token_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.predict_tokens(opcode, in_byte);
            if (out_valid && out_ready)
            begin
                got.kind  = result_kind;
                got.ch    = out_char;
                got.idx   = field_index;
                got.total = field_total;
                got.ovf   = cell_overflow;
                got.last  = last;
                sb.check_token(got);
            end
        end
    end

    // Result side: random stalls, calm stretches and one long hold-off.
    initial
    begin : receiver
        int stall;
        int rx_calm;
        rx_calm   = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_req)
            begin
                out_ready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else
            begin
                if (rx_calm > 0)
                begin
                    rx_calm--;
                    stall = 0;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    rx_calm = $urandom_range(10, 40);
                    stall   = 0;
                end
                else
                    stall = $urandom_range(0, 6);
                if (stall > 0)
                begin
                    out_ready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void put_data(logic [7:0] b);
        line_q.push_back({OP_DATA, b});
    endfunction

    function automatic void put_eol();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        line_q.push_back({OP_EOL, junk});
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_data(s[i]);
    endfunction

    // Field content byte: letters, blanks of every kind, or anything but comma and quote.
    function automatic logic [7:0] pick_text();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0: c = CH_SPACE;
            1: c = CH_TAB;
            2: c = 8'($urandom_range(WS_LAST, WS_FIRST));
            3: c = 8'($urandom_range(0, 255));
            default: c = 8'($urandom_range(8'h7A, 8'h61));
        endcase
        if (c == CH_COMMA || c == CH_QUOTE)
            c = "x";
        return c;
    endfunction

    function automatic void put_plain();
        repeat ($urandom_range(0, 2))
            put_data($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        repeat ($urandom_range(0, 8))
            put_data(pick_text());
    endfunction

    function automatic void put_quoted();
        if ($urandom_range(0, 1))
            put_data(CH_SPACE);
        put_data(CH_QUOTE);
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 5))
                0: put_text("\"\"");
                1: put_data(CH_COMMA);
                default: put_data(pick_text());
            endcase
        end
        // leave some quotes open so the field runs to the line end
        if ($urandom_range(0, 7) != 0)
        begin
            put_data(CH_QUOTE);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2))
                    put_data(pick_text());
        end
    endfunction

    function automatic void put_line();
        int nfields;
        nfields = $urandom_range(1, 6);
        for (int i = 0; i < nfields; i++)
        begin
            if (i > 0)
                put_data(CH_COMMA);
            if ($urandom_range(0, 2) == 0)
                put_quoted();
            else
                put_plain();
        end
        if ($urandom_range(0, 4) == 0)
            put_data(CH_COMMA);
        put_eol();
    endfunction

    function automatic void put_noise();
        logic       op;
        logic [7:0] b;
        repeat ($urandom_range(1, 12))
        begin
            op = ($urandom_range(0, 7) == 0) ? OP_EOL : OP_DATA;
            b  = 8'($urandom_range(0, 255));
            line_q.push_back({op, b});
        end
        put_eol();
    endfunction

    function automatic logic [6:0] pick_limit();
        case ($urandom_range(0, 4))
            0: return 7'd1;
            1: return 7'd2;
            2: return 7'd63;
            3: return FIELD_LIMIT;
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    // Entered and left at a falling edge; valid stays up unless a gap follows.
    task automatic send_word(logic op, logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode   = op;
        in_byte  = b;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_line();
        tx_burst = ($urandom_range(0, 3) == 0);
        foreach (line_q[i])
        begin
            send_word(line_q[i][8], line_q[i][7:0]);
            items_sent++;
        end
        line_q.delete();
    endtask

    // Hold the input until every predicted word is out and the pipe is empty.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.waiting() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_field_cap(logic [6:0] v);
        cfg_field_cap = v;
        cfg_valid     = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.limit_reg = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin : stimulus
        sb            = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_field_cap = '0;
        in_valid      = 1'b0;
        opcode        = OP_DATA;
        in_byte       = '0;
        rx_hold_req   = 1'b0;
        tx_burst      = 1'b0;
        items_sent    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty line, quoted field with doubled quote and junk, zero and 0xFF bytes,
        // trailing blank, empty field, quote at line end, unclosed quote, trailing comma
        put_eol();
        put_text(" \t\"a\"\"\"z,");
        put_data(8'h00);
        put_data(8'hFF);
        put_text(" ,,\"");
        put_eol();
        put_text("\"q\"");
        put_eol();
        put_text("\",");
        put_eol();
        put_text("x,");
        put_eol();
        send_line();

        // more fields than the limit: index 63 and total 64
        repeat (66) put_text("k,");
        put_eol();
        send_line();

        wait_idle();
        write_field_cap(7'd1);
        put_text("a,b,c");
        put_eol();
        send_line();

        // long cell under a long output hold-off
        wait_idle();
        write_field_cap(FIELD_LIMIT);
        rx_hold_req = 1'b1;
        put_text("  ");
        repeat (300) put_data(pick_text());
        put_text(",y");
        put_eol();
        send_line();

        // long blank runs, inner then trailing
        put_text("a");
        repeat (35) put_data(CH_SPACE);
        put_text("b,c");
        repeat (34) put_data(CH_TAB);
        put_eol();
        send_line();

        items_sent = 0;
        while (items_sent < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                wait_idle();
                write_field_cap(pick_limit());
            end
            if ($urandom_range(0, 7) == 0)
                put_noise();
            else
                put_line();
            send_line();
        end

        wait_idle();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
